// ----- hw/rtl/ppp_pkg.sv -----
package ppp_pkg;

    localparam int QUO_BITS = 41;
    localparam int NX_W     = 43;
    localparam int SIZE_W   = 14;
    localparam int CFG_W    = 64;
    localparam int PROD_W   = NX_W + SIZE_W + 1;

    typedef enum logic [2:0] {
        REG_ROW0_AB  = 3'd0,
        REG_ROW0_CD  = 3'd1,
        REG_ROW1_AB  = 3'd2,
        REG_ROW1_CD  = 3'd3,
        REG_DEPTH_AB = 3'd4,
        REG_DEPTH_CD = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic ok;
        logic scr;
        logic negx;
        logic negy;
    } side_t;

endpackage

// ----- hw/rtl/ppp_dot.sv -----
module ppp_dot
    import ppp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             adv,
    input  logic [CFG_W-1:0]                 ab,
    input  logic [CFG_W-1:0]                 cd,
    input  logic signed [31:0]               px,
    input  logic signed [31:0]               py,
    input  logic signed [31:0]               pz,
    output logic signed [66-FRAC_BITS-1:0]   dot
);

    localparam int SUM_W = 66 - FRAC_BITS;

    logic signed [63:0]      pa_reg, pb_reg, pc_reg;
    logic signed [31:0]      tr_reg;
    logic signed [SUM_W-1:0] dot_reg, dot_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg  <= $signed(ab[31:0])  * px;
            pb_reg  <= $signed(ab[63:32]) * py;
            pc_reg  <= $signed(cd[31:0])  * pz;
            tr_reg  <= $signed(cd[63:32]);
            dot_reg <= dot_next;
        end
    end

    always_comb
    begin
        dot_next = SUM_W'(pa_reg >>> FRAC_BITS) + SUM_W'(pb_reg >>> FRAC_BITS)
                 + SUM_W'(pc_reg >>> FRAC_BITS) + SUM_W'(tr_reg);
    end

    assign dot = dot_reg;

endmodule

// ----- hw/rtl/ppp_div.sv -----
module ppp_div
    import ppp_pkg::*;
#(
    parameter int NUM_W = 66,
    parameter int DEN_W = 50
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic [QUO_BITS-1:0]  quo,
    output logic                 ovf
);

    localparam int RW = DEN_W + 1;

    logic [RW-1:0]       r_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] q_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] n_reg [0:QUO_BITS];
    logic [DEN_W-1:0]    d_reg [0:QUO_BITS];
    logic                o_reg [0:QUO_BITS];
    logic [RW-1:0]       r_next [1:QUO_BITS];
    logic [QUO_BITS-1:0] q_next [1:QUO_BITS];
    logic [NUM_W-1:0]    hi;

    assign hi = num >> QUO_BITS;

    always_comb
    begin
        logic [RW:0] t;
        logic        ge;
        t = '0;
        ge = 1'b0;
        for (int i = 1; i <= QUO_BITS; i++)
        begin
            t = {r_reg[i-1], n_reg[i-1][QUO_BITS-i]};
            ge = t >= (RW+1)'(d_reg[i-1]);
            r_next[i] = ge ? RW'(t - (RW+1)'(d_reg[i-1])) : RW'(t);
            q_next[i] = q_reg[i-1] | (QUO_BITS'(ge) << (QUO_BITS - i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0] <= hi[RW-1:0];
            q_reg[0] <= '0;
            n_reg[0] <= num[QUO_BITS-1:0];
            d_reg[0] <= den;
            o_reg[0] <= hi >= NUM_W'(den);
            for (int i = 1; i <= QUO_BITS; i++)
            begin
                r_reg[i] <= r_next[i];
                q_reg[i] <= q_next[i];
                n_reg[i] <= n_reg[i-1];
                d_reg[i] <= d_reg[i-1];
                o_reg[i] <= o_reg[i-1];
            end
        end
    end

    assign quo = q_reg[QUO_BITS];
    assign ovf = o_reg[QUO_BITS];

endmodule

// ----- hw/rtl/perspective_point_projector_top.sv -----
// channel | signals                                   | beat when
// in      | in_valid in_stall operation pos_x/y/z     | in_valid & !in_stall
// out     | out_valid out_stall visible screen_x/y    | out_valid & !out_stall
//         |   inv_depth                               |
// cfg     | cfg_write_en cfg_index cfg_data           | cfg_write_en
// One point per cycle sustained while out_stall does not hold the pipe; the
// 41-step restoring divider pipelines compute x/w, y/w and 1/w.
// The whole pipe advances as one when the output register is empty or taken;
// in_stall is high only while a finished beat waits under out_stall.
// Reset clears valid bits and loads the default registers and screen size.
module perspective_point_projector_top
    import ppp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     operation,
    input  logic signed [31:0]       pos_x,
    input  logic signed [31:0]       pos_y,
    input  logic signed [31:0]       pos_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     visible,
    output logic signed [31:0]       screen_x,
    output logic signed [31:0]       screen_y,
    output logic [30:0]              inv_depth,
    input  logic                     cfg_write_en,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int SUM_W = 66 - FRAC_BITS;
    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam logic signed [SUM_W-1:0] W_FLOOR = SUM_W'((64'sd1 <<< FRAC_BITS) / 1000);
    localparam logic signed [SUM_W-1:0] W_CEIL  =
        SUM_W'(((64'sd1 <<< FRAC_BITS) + 999) / 1000);
    localparam logic [QUO_BITS-1:0] Q_MAX = QUO_BITS'(1) << (QUO_BITS - 1);
    localparam logic [QUO_BITS-1:0] INV_MAX = QUO_BITS'(31'h7FFF_FFFF);
    localparam logic signed [NX_W-1:0] ONE_NX = NX_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ONE_P = PROD_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ZERO_P = '0;
    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(32'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sd2147483648);

    logic [CFG_W-1:0]  r0ab_reg, r0cd_reg, r1ab_reg, r1cd_reg, dab_reg, dcd_reg;
    logic [SIZE_W-1:0] sw_reg, sh_reg;
    logic adv;

    logic va_reg, vb_reg, vd_reg, ve_reg, out_valid_reg;
    logic vq_reg [0:QUO_BITS];
    side_t sq_reg [0:QUO_BITS];
    logic ma_reg, mb_reg;

    logic signed [SUM_W-1:0] cx, cy, w;
    side_t side_b;
    logic [SUM_W-1:0] magx, magy;
    logic [QUO_BITS-1:0] qx, qy, qi;
    logic ox, oy, oi;

    logic signed [NX_W-1:0] nx_reg, ny_reg, nx_next, ny_next;
    logic [30:0] invd_reg, invd_next, inve_reg;
    logic okd_reg, scrd_reg, oke_reg, scre_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, vx, vy;
    logic signed [31:0] sx_next, sy_next;

    logic visible_reg;
    logic signed [31:0] screen_x_reg, screen_y_reg;
    logic [30:0] inv_depth_reg;

    assign adv = !out_valid_reg || !out_stall;
    assign in_stall = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0ab_reg <= '0;
            r0cd_reg <= '0;
            r1ab_reg <= '0;
            r1cd_reg <= '0;
            dab_reg  <= '0;
            dcd_reg  <= '0;
            sw_reg   <= SIZE_W'(1920);
            sh_reg   <= SIZE_W'(1080);
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW0_AB:  r0ab_reg <= cfg_data;
                REG_ROW0_CD:  r0cd_reg <= cfg_data;
                REG_ROW1_AB:  r1ab_reg <= cfg_data;
                REG_ROW1_CD:  r1cd_reg <= cfg_data;
                REG_DEPTH_AB: dab_reg  <= cfg_data;
                REG_DEPTH_CD: dcd_reg  <= cfg_data;
                REG_WIDTH:    sw_reg   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:   sh_reg   <= cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
        .clk(clk), .adv(adv), .ab(r0ab_reg), .cd(r0cd_reg),
        .px(pos_x), .py(pos_y), .pz(pos_z), .dot(cx)
    );
    ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
        .clk(clk), .adv(adv), .ab(r1ab_reg), .cd(r1cd_reg),
        .px(pos_x), .py(pos_y), .pz(pos_z), .dot(cy)
    );
    ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
        .clk(clk), .adv(adv), .ab(dab_reg), .cd(dcd_reg),
        .px(pos_x), .py(pos_y), .pz(pos_z), .dot(w)
    );

    always_comb
    begin
        side_b.scr  = mb_reg;
        side_b.negx = cx < 0;
        side_b.negy = cy < 0;
        if (mb_reg)
            side_b.ok = w > W_FLOOR;
        else
            side_b.ok = (w >= W_CEIL) && (cx >= -w) && (cx <= w) && (cy >= -w) && (cy <= w);
        magx = side_b.negx ? SUM_W'(-cx) : SUM_W'(cx);
        magy = side_b.negy ? SUM_W'(-cy) : SUM_W'(cy);
    end

    ppp_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_x (
        .clk(clk), .adv(adv), .num(NUM_W'(magx) << FRAC_BITS), .den(SUM_W'(w)),
        .quo(qx), .ovf(ox)
    );
    ppp_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_y (
        .clk(clk), .adv(adv), .num(NUM_W'(magy) << FRAC_BITS), .den(SUM_W'(w)),
        .quo(qy), .ovf(oy)
    );
    ppp_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div_i (
        .clk(clk), .adv(adv), .num(NUM_W'(1) << (2 * FRAC_BITS)), .den(SUM_W'(w)),
        .quo(qi), .ovf(oi)
    );

    always_comb
    begin
        logic [QUO_BITS-1:0] mx, my;
        mx = (ox || qx > Q_MAX) ? Q_MAX : qx;
        my = (oy || qy > Q_MAX) ? Q_MAX : qy;
        nx_next = sq_reg[QUO_BITS].negx ? -NX_W'(mx) : NX_W'(mx);
        ny_next = sq_reg[QUO_BITS].negy ? -NX_W'(my) : NX_W'(my);
        invd_next = (oi || qi > INV_MAX) ? 31'h7FFF_FFFF : qi[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ma_reg <= operation;
            mb_reg <= ma_reg;
            sq_reg[0] <= side_b;
            for (int i = 1; i <= QUO_BITS; i++)
                sq_reg[i] <= sq_reg[i-1];
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            invd_reg <= invd_next;
            okd_reg  <= sq_reg[QUO_BITS].ok;
            scrd_reg <= sq_reg[QUO_BITS].scr;
            px_reg   <= PROD_W'(nx_reg + ONE_NX) * $signed({1'b0, sw_reg});
            py_reg   <= PROD_W'(ONE_NX - ny_reg) * $signed({1'b0, sh_reg});
            inve_reg <= invd_reg;
            oke_reg  <= okd_reg;
            scre_reg <= scrd_reg;
            visible_reg   <= oke_reg;
            screen_x_reg  <= oke_reg ? sx_next : '0;
            screen_y_reg  <= oke_reg ? sy_next : '0;
            inv_depth_reg <= (oke_reg && !scre_reg) ? inve_reg : '0;
        end
    end

    always_comb
    begin
        vx = (px_reg + (scre_reg ? ONE_P : ZERO_P)) >>> 1;
        vy = (py_reg - (scre_reg ? ONE_P : ZERO_P)) >>> 1;
        if (vx > S32_MAX)
            sx_next = 32'sh7FFF_FFFF;
        else if (vx < S32_MIN)
            sx_next = 32'sh8000_0000;
        else
            sx_next = vx[31:0];
        if (vy > S32_MAX)
            sy_next = 32'sh7FFF_FFFF;
        else if (vy < S32_MIN)
            sy_next = 32'sh8000_0000;
        else
            sy_next = vy[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int i = 0; i <= QUO_BITS; i++)
                vq_reg[i] <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vq_reg[0] <= vb_reg;
            for (int i = 1; i <= QUO_BITS; i++)
                vq_reg[i] <= vq_reg[i-1];
            vd_reg <= vq_reg[QUO_BITS];
            ve_reg <= vd_reg;
            out_valid_reg <= ve_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;
    assign inv_depth = inv_depth_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> screen_x == 0 && screen_y == 0 && inv_depth == 0)
        else $error("rejected point carries nonzero result");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && ve_reg |=> out_valid)
        else $error("beat lost between last stage and output");

endmodule
